/* src/ctr_pkg.sv */
// ctr_pkg: shared constants, codes and payload types of the call/return tracer.
// Used by ctr_search, call_return_tracer and ctr_checker. No dependencies.
package ctr_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int STACK_DEPTH = 64;
   localparam int LOG_LIMIT   = 1024;

   localparam int ADDR_W = 32;
   localparam int TAG_W  = 16;

   localparam int TIDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TCNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DEPTH_W = 7;
   localparam int EVT_W   = $clog2(LOG_LIMIT + 1);

   // operation codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_CALL   = 2'd2;
   localparam logic [1:0] OP_RETURN = 2'd3;

   // event kinds
   localparam logic KIND_CALL   = 1'b0;
   localparam logic KIND_RETURN = 1'b1;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] pc;
      logic [ADDR_W-1:0] target;
      logic [ADDR_W-1:0] sym_start;
      logic [ADDR_W-1:0] sym_size;
      logic [TAG_W-1:0]  sym_tag;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [ADDR_W-1:0]  event_pc;
      logic [ADDR_W-1:0]  event_target;
      logic [DEPTH_W-1:0] depth;
      logic               found;
      logic [TAG_W-1:0]   found_tag;
   } rsp_type;

   // symbol table entry: [start, limit)
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] limit;
      logic [TAG_W-1:0]  tag;
   } sym_entry_type;

   typedef struct packed {
      logic              clear;
      logic              load;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
      logic [TAG_W-1:0]  tag;
      logic              find;
      logic [ADDR_W-1:0] addr;
   } srch_req_type;

   typedef struct packed {
      logic             done;
      logic             hit;
      logic [TAG_W-1:0] tag;
   } srch_rsp_type;

endpackage

/* src/ctr_search.sv */
// ctr_search: symbol range table in a synchronous RAM plus the binary search sequencer.
// Depends on ctr_pkg.
module ctr_search import ctr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  srch_req_type srch_req,
   output srch_rsp_type srch_rsp
);

   typedef enum logic [1:0] {
      SRCH_IDLE  = 2'b01,
      SRCH_PROBE = 2'b10
   } srch_state_type;

   srch_state_type    state_ff, state_in;
   logic [TCNT_W-1:0] count_ff, count_in;
   logic [TCNT_W-1:0] lo_ff, lo_in;
   logic [TCNT_W-1:0] hp_ff, hp_in;     // upper bound, exclusive
   logic [TCNT_W-1:0] mid_ff, mid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              done_ff, done_in;
   logic              hit_ff, hit_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;

   sym_entry_type     table_mem [TABLE_DEPTH];
   sym_entry_type     rd_data_ff;
   sym_entry_type     wr_data;
   logic              wr_en;
   logic [TIDX_W-1:0] rd_idx;

   function automatic logic [TCNT_W-1:0] mid_of(input logic [TCNT_W-1:0] lo,
                                                input logic [TCNT_W-1:0] hp);
      logic [TCNT_W-1:0] span;
      span = hp - lo - TCNT_W'(1);
      return lo + (span >> 1);
   endfunction

   // load: zero size counts as one, limit wraps at 32 bits
   always_comb begin
      wr_en         = srch_req.load && (count_ff < TCNT_W'(TABLE_DEPTH));
      wr_data.start = srch_req.start;
      wr_data.limit = srch_req.start
                    + ((srch_req.size == '0) ? ADDR_W'(1) : srch_req.size);
      wr_data.tag   = srch_req.tag;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      hp_in    = hp_ff;
      mid_in   = mid_ff;
      addr_in  = addr_ff;
      done_in  = 1'b0;
      hit_in   = 1'b0;
      tag_in   = '0;
      if (srch_req.clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + TCNT_W'(1);
      end
      case (state_ff)
         SRCH_IDLE: begin
            lo_in  = '0;
            hp_in  = count_ff;
            mid_in = mid_of('0, count_ff);
            if (srch_req.find) begin
               addr_in = srch_req.addr;
               if (count_ff != '0) begin
                  state_in = SRCH_PROBE;
               end else begin
                  done_in = 1'b1;
               end
            end
         end
         SRCH_PROBE: begin
            if (addr_ff < rd_data_ff.start) begin
               hp_in = mid_ff;
            end else if (addr_ff >= rd_data_ff.limit) begin
               lo_in = mid_ff + TCNT_W'(1);
            end else begin
               done_in  = 1'b1;
               hit_in   = 1'b1;
               tag_in   = rd_data_ff.tag;
               state_in = SRCH_IDLE;
            end
            if (!hit_in) begin
               mid_in = mid_of(lo_in, hp_in);
               if (lo_in >= hp_in) begin
                  done_in  = 1'b1;
                  state_in = SRCH_IDLE;
               end
            end
         end
         default: begin
            state_in = SRCH_IDLE;
         end
      endcase
      rd_idx = mid_in[TIDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SRCH_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      lo_ff   <= lo_in;
      hp_ff   <= hp_in;
      mid_ff  <= mid_in;
      addr_ff <= addr_in;
      hit_ff  <= hit_in;
      tag_ff  <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[count_ff[TIDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_idx];
   end

   assign srch_rsp.done = done_ff;
   assign srch_rsp.hit  = hit_ff;
   assign srch_rsp.tag  = tag_ff;

endmodule

/* src/call_return_tracer.sv */
// call_return_tracer: top level of the call/return tracer; holds the call stack RAM,
// event counter and result register. Depends on ctr_pkg and ctr_search.
// Clear and load never raise busy. A return gives its result from ST_POP through the
// result register. A call gives it once the search is done, one probe per cycle through
// the symbol table RAM read port: at most 11 probes with 1024 entries.
// One item at a time; busy is high until the result cycle, start is taken again in it.
// Synchronous active-high reset (and the clear operation) empties table, stack and log.
module call_return_tracer import ctr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_POP    = 3'b100
   } state_type;

   typedef struct packed {
      logic             found;
      logic [TAG_W-1:0] tag;
   } frame_type;

   state_type          state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [EVT_W-1:0]   events_ff, events_in;
   logic [ADDR_W-1:0]  pc_ff, pc_in;
   logic [ADDR_W-1:0]  target_ff, target_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   // call stack: RAM with a valid bit per slot so that clear is instant
   frame_type          frame_mem [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] frame_vld_ff;
   frame_type          frame_rd_ff;
   logic               frame_rd_vld_ff;
   logic               frame_wr;
   frame_type          frame_wr_data;
   logic               frame_clear;
   logic [SIDX_W-1:0]  frame_rd_idx;

   srch_req_type       srch_req;
   srch_rsp_type       srch_rsp;

   logic               accept;
   logic               log_open;
   logic               pop_hit;

   ctr_search u_search (
      .clock    (clock),
      .reset    (reset),
      .srch_req (srch_req),
      .srch_rsp (srch_rsp)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign log_open = events_ff < EVT_W'(LOG_LIMIT);
   // unwritten or cleared slots read as an empty frame
   assign pop_hit  = frame_rd_vld_ff && frame_rd_ff.found;

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      events_in     = events_ff;
      pc_in         = pc_ff;
      target_in     = target_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      frame_wr      = 1'b0;
      frame_wr_data = '0;
      frame_clear   = 1'b0;

      srch_req.clear = 1'b0;
      srch_req.load  = 1'b0;
      srch_req.start = req_payload.sym_start;
      srch_req.size  = req_payload.sym_size;
      srch_req.tag   = req_payload.sym_tag;
      srch_req.find  = 1'b0;
      srch_req.addr  = req_payload.target;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_payload.op)
                  OP_CLEAR: begin
                     depth_in       = '0;
                     events_in      = '0;
                     frame_clear    = 1'b1;
                     srch_req.clear = 1'b1;
                  end
                  OP_LOAD: begin
                     srch_req.load = 1'b1;
                  end
                  OP_CALL: begin
                     srch_req.find = 1'b1;
                     pc_in         = req_payload.pc;
                     target_in     = req_payload.target;
                     state_in      = ST_SEARCH;
                  end
                  OP_RETURN: begin
                     // pop below zero reads slot 0 as it stands
                     if (depth_ff != '0) begin
                        depth_in = depth_ff - DEPTH_W'(1);
                     end
                     pc_in    = req_payload.pc;
                     state_in = ST_POP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (srch_rsp.done) begin
               state_in = ST_IDLE;
               if (log_open) begin
                  rsp_strobe_in       = 1'b1;
                  events_in           = events_ff + EVT_W'(1);
                  rsp_in.kind         = KIND_CALL;
                  rsp_in.event_pc     = pc_ff;
                  rsp_in.event_target = target_ff;
                  rsp_in.depth        = depth_ff;
                  rsp_in.found        = srch_rsp.hit;
                  rsp_in.found_tag    = srch_rsp.hit ? srch_rsp.tag : '0;
               end
               // full stack: event still reported, frame dropped
               if (depth_ff < DEPTH_W'(STACK_DEPTH)) begin
                  frame_wr            = 1'b1;
                  frame_wr_data.found = srch_rsp.hit;
                  frame_wr_data.tag   = srch_rsp.hit ? srch_rsp.tag : '0;
                  depth_in            = depth_ff + DEPTH_W'(1);
               end
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
            if (log_open) begin
               rsp_strobe_in       = 1'b1;
               events_in           = events_ff + EVT_W'(1);
               rsp_in.kind         = KIND_RETURN;
               rsp_in.event_pc     = pc_ff;
               rsp_in.event_target = '0;
               rsp_in.depth        = depth_ff;
               rsp_in.found        = pop_hit;
               rsp_in.found_tag    = pop_hit ? frame_rd_ff.tag : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      frame_rd_idx = depth_in[SIDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         depth_ff      <= '0;
         events_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         frame_vld_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         events_ff     <= events_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (frame_clear) begin
            frame_vld_ff <= '0;
         end else if (frame_wr) begin
            frame_vld_ff[depth_ff[SIDX_W-1:0]] <= 1'b1;
         end
      end
      pc_ff     <= pc_in;
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (frame_wr) begin
         frame_mem[depth_ff[SIDX_W-1:0]] <= frame_wr_data;
      end
      frame_rd_ff     <= frame_mem[frame_rd_idx];
      frame_rd_vld_ff <= frame_vld_ff[frame_rd_idx];
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* src/ctr_checker.sv */
// ctr_checker: port-level assertions for call_return_tracer, bound to the top level.
// Depends on ctr_pkg.
module ctr_checker import ctr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   // every result closes a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result without preceding busy period");

   // one result per transfer: never two strobes in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // a call or return transfer always makes the block busy
   a_busy_after_event: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.op == OP_CALL || req_payload.op == OP_RETURN))
      |=> busy)
      else $error("call or return not taken up");

   a_return_no_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.kind == KIND_RETURN) |-> (rsp_payload.event_target == '0))
      else $error("return event carries a target");

   a_miss_tag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.found) |-> (rsp_payload.found_tag == '0))
      else $error("tag set on a miss");

endmodule

bind call_return_tracer ctr_checker u_ctr_checker (.*);
